// File: src/uart_tx_even_parity_fifo_macros.svh
// Assertion macros shared by the transmitter RTL.
`ifndef UART_TX_EVEN_PARITY_FIFO_MACROS_SVH
`define UART_TX_EVEN_PARITY_FIFO_MACROS_SVH

`ifndef SYNTHESIS
`define UTX_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define UTX_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define UTX_ASSERT(name, clk, rst, prop, msg)
`define UTX_ASSERT_IMPLY(name, clk, rst, pre, post, msg)
`endif

`endif

// File: src/uarttx_pkg.sv
package uarttx_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 64;
   localparam int FRAME_BITS = 11;
   localparam int LEVEL_WIDTH = 7;
   localparam int LEVEL_MAX = 127;

   localparam logic [3:0] CNT_IDLE = 4'd11;
   localparam logic START_BIT = 1'b0;
   localparam logic STOP_BIT = 1'b1;
   localparam logic LINE_IDLE = 1'b1;

   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef logic [FRAME_BITS-1:0] frame_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   line_bit;
      logic                   bit_driven;
      logic [LEVEL_WIDTH-1:0] queue_level;
   } rsp_type;

   // Start bit, data LSB first, even parity, one stop bit.
   function automatic frame_type make_frame(input logic [7:0] data_byte);
      return {STOP_BIT, ^data_byte, data_byte, START_BIT};
   endfunction

endpackage

// File: src/uart_tx_even_parity_fifo.sv
// Channel | Ports                          | Carries
// --------+--------------------------------+---------------------------------------
// request | req_valid, req_stall, req_data | send a byte or one baud tick
// result  | rsp_valid, rsp_stall, rsp_data | accepted, line bit, bit driven, level
//
// One request can enter each cycle unless req_stall is high; the result
// register is the only stage. A frame load reads the frame memory, whose data
// arrives in the following cycle and feeds the shifter through a bypass.
// Reset clears pointers, count, shifter; line goes high; frame memory is not cleared.
// Requests stall only while a result is held and the result side stalls.
`include "uart_tx_even_parity_fifo_macros.svh"

module uart_tx_even_parity_fifo #(
   parameter int FIFO_DEPTH = uarttx_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uarttx_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uarttx_pkg::rsp_type rsp_data
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
   localparam int FB = uarttx_pkg::FRAME_BITS;

   uarttx_pkg::frame_type mem [FIFO_DEPTH];
   uarttx_pkg::frame_type rd_data_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   uarttx_pkg::frame_type shift_ff, shift_in, shift_cur;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic line_ff, line_in;
   logic pending_ff, pending_in;
   logic rsp_valid_ff;
   uarttx_pkg::rsp_type rsp_data_ff, rsp_in;

   logic accept, push, tick, idle, load, drive;
   logic [31:0] cnt_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign push = accept && (req_data.mode == uarttx_pkg::MODE_SEND) && (count_ff != CNT_FULL);
   assign tick = accept && (req_data.mode == uarttx_pkg::MODE_TICK);
   assign idle = bit_cnt_ff >= uarttx_pkg::CNT_IDLE;
   assign load = tick && idle && (count_ff != '0);
   assign drive = tick && (load || !idle);

   // The frame read on a load lands in the following cycle with its start bit already sent.
   assign shift_cur = pending_ff ? {1'b0, rd_data_ff[FB-1:1]} : shift_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      shift_in = shift_cur;
      bit_cnt_in = bit_cnt_ff;
      line_in = line_ff;
      pending_in = load;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (load) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in = count_ff - 1'b1;
         bit_cnt_in = 4'd1;
         line_in = uarttx_pkg::START_BIT;
      end else if (drive) begin
         shift_in = shift_cur >> 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
         line_in = shift_cur[0];
      end
   end

   always_comb begin
      cnt_wide = 32'(count_in);
      rsp_in.accepted = push;
      rsp_in.line_bit = line_in;
      rsp_in.bit_driven = drive;
      rsp_in.queue_level = (cnt_wide > 32'(uarttx_pkg::LEVEL_MAX)) ?
         uarttx_pkg::LEVEL_WIDTH'(uarttx_pkg::LEVEL_MAX) : cnt_wide[uarttx_pkg::LEVEL_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= uarttx_pkg::make_frame(req_data.data_byte);
      end
      if (load) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         shift_ff <= '0;
         bit_cnt_ff <= uarttx_pkg::CNT_IDLE;
         line_ff <= uarttx_pkg::LINE_IDLE;
         pending_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         bit_cnt_ff <= bit_cnt_in;
         line_ff <= line_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `UTX_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_FULL, "frame count above depth")
   `UTX_ASSERT_IMPLY(a_ptr_empty_full, clock, reset, (count_ff == '0) || (count_ff == CNT_FULL), wr_ptr_ff == rd_ptr_ff, "pointers differ at empty or full")
   `UTX_ASSERT_IMPLY(a_ptr_partial, clock, reset, (count_ff != '0) && (count_ff != CNT_FULL), wr_ptr_ff != rd_ptr_ff, "pointers match with partial queue")
   `UTX_ASSERT_IMPLY(a_pending_cnt, clock, reset, pending_ff, bit_cnt_ff == 4'd1, "bypass cycle without fresh frame")

endmodule
